// ----- rtl/itf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package itf_pkg;
    localparam int MAX_FIELD_DEF = 255;
    localparam int CHARS_PER_RESULT_DEF = 8;

    typedef struct packed {
        logic [63:0] value;
        logic [4:0]  radix;
        logic        signed_mode;
        logic        upper_digits;
        logic        left_justify;
        logic        force_plus;
        logic        space_sign;
        logic        alt_prefix;
        logic        upper_prefix;
        logic [7:0]  min_width;
        logic [7:0]  min_digits;
    } in_item_t;

    typedef struct packed {
        logic [63:0] chars;
        logic [3:0]  char_count;
        logic        last;
    } out_item_t;

    // Classified job handed from the front part to the back part.
    typedef struct packed {
        logic [63:0] mag;
        logic [4:0]  radix;
        logic        upper_digits;
        logic        left_justify;
        logic [1:0]  plen;
        logic [7:0]  pre0;
        logic [7:0]  pre1;
        logic [7:0]  pre2;
        logic [11:0] width;
        logic [11:0] prec;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LPAD,
        ST_PRE,
        ST_ZERO,
        ST_DIG,
        ST_RPAD
    } back_state_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {4'd0, d};
        else
            c = (up ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
        return c;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/itf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module itf_front
    import itf_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t in_data,
    input  wire logic     in_valid,
    output logic          in_ready,
    output job_t          job,
    output logic          job_valid,
    input  wire logic     job_ready
);
    localparam logic [11:0] MaxF = 12'(MAX_FIELD);

    logic   [1:0]  cnt_reg, cnt_next;
    job_t          q_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    job_t          cls;
    logic          base_ok, neg, alt_ok, push, pop;
    logic   [1:0]  p;
    logic   [7:0]  pc [3];
    logic   [7:0]  letter;

    always_comb
    begin
        base_ok = (in_data.radix >= 5'd2) && (in_data.radix <= 5'd16);
        neg = in_data.signed_mode && in_data.value[63];
        cls.mag = neg ? (64'd0 - in_data.value) : in_data.value;
        cls.radix = in_data.radix;
        cls.upper_digits = in_data.upper_digits;
        cls.left_justify = in_data.left_justify;
        p = 2'd0;
        pc[0] = CH_SPACE;
        pc[1] = CH_SPACE;
        pc[2] = CH_SPACE;
        if (neg || in_data.force_plus || in_data.space_sign)
        begin
            pc[0] = neg ? CH_MINUS : (in_data.force_plus ? CH_PLUS : CH_SPACE);
            p = 2'd1;
        end
        alt_ok = in_data.alt_prefix && (in_data.radix == 5'd2 || in_data.radix == 5'd8
                 || in_data.radix == 5'd16);
        if (in_data.radix == 5'd2)
            letter = in_data.upper_prefix ? 8'h42 : 8'h62;
        else if (in_data.radix == 5'd8)
            letter = in_data.upper_prefix ? 8'h4f : 8'h6f;
        else
            letter = in_data.upper_prefix ? 8'h58 : 8'h78;
        if (alt_ok)
        begin
            pc[p] = CH_ZERO;
            pc[2'(p + 2'd1)] = letter;
            p = p + 2'd2;
        end
        cls.plen = p;
        cls.pre0 = pc[0];
        cls.pre1 = pc[1];
        cls.pre2 = pc[2];
        cls.width = ({4'd0, in_data.min_width} > MaxF) ? MaxF : {4'd0, in_data.min_width};
        cls.prec = ({4'd0, in_data.min_digits} > MaxF) ? MaxF : {4'd0, in_data.min_digits};
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && base_ok;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end
endmodule
`default_nettype wire

// ----- rtl/itf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module itf_back
    import itf_pkg::*;
#(
    parameter int CHARS_PER_RESULT = CHARS_PER_RESULT_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire job_t  job,
    input  wire logic  job_valid,
    output logic       job_ready,
    output out_item_t  out_data,
    output logic       out_valid,
    input  wire logic  out_ready
);
    localparam int CW = $clog2(CHARS_PER_RESULT + 1);

    back_state_t   state_reg, state_next;
    job_t          j_reg;
    logic [63:0]   quo_reg, rem_reg;
    logic [6:0]    bit_reg;
    logic [255:0]  dig_reg;
    logic [6:0]    ndig_reg;
    logic [11:0]   cnt_reg;
    logic [63:0]   acc_reg;
    logic [CW-1:0] fill_reg;
    out_item_t     out_reg;
    logic          out_valid_reg;

    logic [64:0]   rshift;
    logic          rge;
    logic [11:0]   ndig12, body, pad;
    logic          emit, fin, last_ch, word_done, stall;
    logic [7:0]    ch;
    logic [1:0]    pidx;
    logic [63:0]   word;

    assign rshift    = {rem_reg, quo_reg[63]};
    assign rge       = rshift >= {60'd0, j_reg.radix};
    assign ndig12    = {5'd0, ndig_reg};
    assign body      = {10'd0, j_reg.plen} + ((j_reg.prec > ndig12) ? j_reg.prec : ndig12);
    assign pad       = (j_reg.width > body) ? j_reg.width - body : 12'd0;
    assign job_ready = (state_reg == ST_IDLE);
    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;
    assign pidx      = cnt_reg[1:0];

    always_comb
    begin
        state_next = state_reg;
        emit = 1'b0;
        last_ch = 1'b0;
        ch = CH_SPACE;
        unique case (state_reg)
            ST_IDLE:
                if (job_valid)
                    state_next = ST_DIV;
            ST_DIV:
                if (bit_reg == 7'd0 && quo_reg == 64'd0)
                    state_next = ST_LPAD;
            ST_LPAD:
            begin
                if (!j_reg.left_justify && cnt_reg < pad)
                    emit = 1'b1;
                else
                    state_next = ST_PRE;
            end
            ST_PRE:
            begin
                if (cnt_reg < {10'd0, j_reg.plen})
                begin
                    emit = 1'b1;
                    ch = (pidx == 2'd0) ? j_reg.pre0 : ((pidx == 2'd1) ? j_reg.pre1 : j_reg.pre2);
                end
                else
                    state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                if (cnt_reg + ndig12 < j_reg.prec)
                begin
                    emit = 1'b1;
                    ch = CH_ZERO;
                end
                else
                    state_next = ST_DIG;
            end
            ST_DIG:
            begin
                emit = 1'b1;
                ch = digit_char(dig_reg[255:252], j_reg.upper_digits);
                if (cnt_reg[6:0] == ndig_reg - 7'd1)
                begin
                    if (j_reg.left_justify && pad != 12'd0)
                        state_next = ST_RPAD;
                    else
                    begin
                        last_ch = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RPAD:
            begin
                emit = 1'b1;
                if (cnt_reg == pad - 12'd1)
                begin
                    last_ch = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        word_done = last_ch || (fill_reg == CW'(CHARS_PER_RESULT - 1));
        stall = emit && word_done && out_valid_reg && !out_ready;
        fin = emit && !stall;
        if (stall)
            state_next = state_reg;
        word = acc_reg;
        word[8*fill_reg +: 8] = ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (fin && word_done)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (fin)
            begin
                if (word_done)
                    fill_reg <= '0;
                else
                    fill_reg <= fill_reg + CW'(1);
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin && word_done)
        begin
            out_reg.chars <= word;
            out_reg.char_count <= 4'(fill_reg) + 4'd1;
            out_reg.last <= last_ch;
        end
        if (state_reg == ST_IDLE || (fin && word_done))
            acc_reg <= 64'd0;
        else if (fin)
            acc_reg <= word;
        if (state_reg == ST_IDLE)
        begin
            j_reg <= job;
            quo_reg <= job.mag;
            rem_reg <= 64'd0;
            bit_reg <= 7'd64;
            ndig_reg <= 7'd0;
        end
        else if (state_reg == ST_DIV)
        begin
            if (bit_reg != 7'd0)
            begin
                quo_reg <= {quo_reg[62:0], rge};
                rem_reg <= rge ? 64'(rshift - {60'd0, j_reg.radix}) : rshift[63:0];
                bit_reg <= bit_reg - 7'd1;
            end
            else
            begin
                dig_reg <= {rem_reg[3:0], dig_reg[255:4]};
                ndig_reg <= ndig_reg + 7'd1;
                rem_reg <= 64'd0;
                bit_reg <= 7'd64;
            end
            cnt_reg <= 12'd0;
        end
        else if (!stall)
        begin
            if (state_next != state_reg)
                cnt_reg <= 12'd0;
            else if (emit)
                cnt_reg <= cnt_reg + 12'd1;
            if (fin && state_reg == ST_DIG)
                dig_reg <= {dig_reg[251:0], 4'd0};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/integer_to_text_formatter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A serial shift-subtract divider first extracts the digits; the characters are then emitted, stalling on out_ready.
// Each number is formatted in full before the back end takes the next one, so the serial divider bounds throughput.
// A two-entry queue lets the next number be classified while text is still being emitted.
// Reset: asynchronous, active low; clears the queue, state machine and output valid.
module integer_to_text_formatter
    import itf_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF,
    parameter int CHARS_PER_RESULT = CHARS_PER_RESULT_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t in_data,
    input  wire logic     in_valid,
    output logic          in_ready,
    output out_item_t     out_data,
    output logic          out_valid,
    input  wire logic     out_ready
);
    job_t job;
    logic job_valid, job_ready;

    itf_front #(.MAX_FIELD(MAX_FIELD)) u_front (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
        .in_ready(in_ready), .job(job), .job_valid(job_valid), .job_ready(job_ready)
    );

    itf_back #(.CHARS_PER_RESULT(CHARS_PER_RESULT)) u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid), .job_ready(job_ready),
        .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
    );
endmodule
`default_nettype wire
